// File: design/gda_pkg.sv
// ============================================================================
// gda_pkg - shared types and constants of the Gregorian date arithmetic unit
// Operation codes, sequencer states, calendar constants and the small
// calendar functions (leap year, month length).
// ============================================================================
`default_nettype none

package gda_pkg;

    // Operation codes carried with each request
    typedef enum logic [1:0] {
        FUNC_LOAD    = 2'd0,
        FUNC_ADD     = 2'd1,
        FUNC_SUB     = 2'd2,
        FUNC_COMPARE = 2'd3
    } func_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_C,
        ST_REM,
        ST_CHECK,
        ST_MUL_Y,
        ST_YSUM,
        ST_MON,
        ST_ARITH,
        ST_WALK,
        ST_MONW,
        ST_DONE
    } state_t;

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 16;
    localparam int SERIAL_W = 22;
    localparam int CENT_W   = 8;
    localparam int CREM_W   = 7;
    localparam int MUL_B_W  = 13;
    localparam int MUL_P_W  = 27;

    // Calendar constants
    localparam logic [YEAR_W-1:0]   MAX_YEAR     = 14'd9999;
    localparam logic [SERIAL_W-1:0] LAST_SERIAL  = 22'd3652424;
    localparam logic [MONTH_W-1:0]  MONTH_FIRST  = 4'd1;
    localparam logic [MONTH_W-1:0]  MONTH_FEB    = 4'd2;
    localparam logic [MONTH_W-1:0]  MONTH_LAST   = 4'd12;
    localparam logic [DAY_W-1:0]    DAYS_LONG    = 5'd31;
    localparam logic [DAY_W-1:0]    DAYS_SHORT   = 5'd30;
    localparam logic [DAY_W-1:0]    DAYS_FEB     = 5'd28;
    localparam logic [DAY_W-1:0]    DAYS_FEB_LP  = 5'd29;
    localparam logic [8:0]          DAYS_YEAR    = 9'd365;
    localparam logic [8:0]          DAYS_YEAR_LP = 9'd366;
    localparam logic [CREM_W-1:0]   CREM_MAX     = 7'd99;

    // Multiplier constants: year length and reciprocal of 100 (scaled by 2^19)
    localparam logic [MUL_B_W-1:0]  MUL_YEAR     = 13'd365;
    localparam logic [MUL_B_W-1:0]  MUL_RECIP100 = 13'd5243;
    localparam int                  RECIP_SHIFT  = 19;

    // Leap year from year mod 4, century mod 4 and year mod 100
    function automatic logic is_leap(input logic [1:0]        y_lo,
                                     input logic [1:0]        c_lo,
                                     input logic [CREM_W-1:0] r100);
        is_leap = (y_lo == 2'd0) && ((r100 != '0) || (c_lo == 2'd0));
    endfunction

    // Length of a month, zero for a month code outside the calendar
    function automatic logic [DAY_W-1:0] month_days(input logic               leap,
                                                    input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAYS_LONG;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAYS_SHORT;
            MONTH_FEB:                                  len = leap ? DAYS_FEB_LP : DAYS_FEB;
            default:                                    len = '0;
        endcase
        month_days = len;
    endfunction

endpackage

`default_nettype wire

// File: design/gregorian_date_arithmetic_unit.sv
// ============================================================================
// gregorian_date_arithmetic_unit - Gregorian date add, subtract and compare
// Holds one date (reset 1900-01-01) and runs load, add days, subtract days
// and compare requests on it under a small sequencer with one shared
// multiplier.
// ============================================================================
// One request is taken at a time; s_axis_tready is high only while the
// sequencer is idle, and a finished result may wait in the output register
// while the next request is taken. A date is turned into a day number with
// two passes of the shared multiplier (century by reciprocal, then 365 times
// the year) and one month length added per cycle. Add and subtract then walk
// the year one calendar year per cycle from the held year and finish with
// one month per cycle. Out of range add or subtract leaves the date
// unchanged and sets range_error; an invalid given date sets date_invalid.
`default_nettype none

module gregorian_date_arithmetic_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: day_count[15:0], other_year[29:16], other_month[33:30],
    //        other_day[38:34], zero pad [39]
    input  wire logic [39:0] s_axis_tdata,
    // tuser: func[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // result channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: year[13:0], month[17:14], day[22:18], is_later[23],
    //        is_equal[24], day_distance[46:25], date_invalid[47],
    //        range_error[48], zero pad [55:49]
    output logic [55:0]      m_axis_tdata
);

    localparam int YW = gda_pkg::YEAR_W;
    localparam int MW = gda_pkg::MONTH_W;
    localparam int DW = gda_pkg::DAY_W;
    localparam int SW = gda_pkg::SERIAL_W;
    localparam int CW = gda_pkg::CENT_W;
    localparam int RW = gda_pkg::CREM_W;

    gda_pkg::state_t state_reg, state_next;

    // request fields
    gda_pkg::func_t                  func_reg, func_next;
    logic [gda_pkg::COUNT_W-1:0]     cnt_reg, cnt_next;
    logic [YW-1:0]                   oy_reg, oy_next;
    logic [MW-1:0]                   om_reg, om_next;
    logic [DW-1:0]                   od_reg, od_next;

    // held date
    logic [YW-1:0] held_year_reg, held_year_next;
    logic [MW-1:0] held_month_reg, held_month_next;
    logic [DW-1:0] held_day_reg, held_day_next;

    // work registers
    logic          phase_reg, phase_next;
    logic [YW-1:0] cy_reg, cy_next;
    logic [MW-1:0] cm_reg, cm_next;
    logic [DW-1:0] cd_reg, cd_next;
    logic [CW-1:0] cc_reg, cc_next;
    logic [RW-1:0] cr_reg, cr_next;
    logic [MW-1:0] k_reg, k_next;
    logic [SW-1:0] acc_reg, acc_next;
    logic [SW-1:0] ys_reg, ys_next;
    logic [SW-1:0] sb_reg, sb_next;
    logic [SW-1:0] dist_reg, dist_next;
    logic          inv_reg, inv_next;
    logic          rerr_reg, rerr_next;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic [YW-1:0] m_year_reg, m_year_next;
    logic [MW-1:0] m_month_reg, m_month_next;
    logic [DW-1:0] m_day_reg, m_day_next;
    logic          m_later_reg, m_later_next;
    logic          m_equal_reg, m_equal_next;
    logic [SW-1:0] m_dist_reg, m_dist_next;
    logic          m_inv_reg, m_inv_next;
    logic          m_rerr_reg, m_rerr_next;

    // shared multiplier
    logic [gda_pkg::MUL_B_W-1:0] mul_b;
    logic [gda_pkg::MUL_P_W-1:0] mul_prod;

    // calendar helpers
    logic          leap_cur;
    logic          leap_prev;
    logic [1:0]    prev_y_lo;
    logic [1:0]    prev_c_lo;
    logic [RW-1:0] prev_r;
    logic [DW-1:0] dim_k;
    logic [DW-1:0] dim_cm;
    logic          date_ok;
    logic [14:0]   cent_x100;
    logic [11:0]   q4, q100, q400, lb;
    logic          r_nz;
    logic [8:0]    walk_len;
    logic [SW-1:0] walk_ys;
    logic [SW-1:0] add_sum;
    logic          cmp_later;
    logic          cmp_equal;
    logic          out_free;

    assign s_axis_tready = (state_reg == gda_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_rerr_reg, m_inv_reg, m_dist_reg, m_equal_reg,
                            m_later_reg, m_day_reg, m_month_reg, m_year_reg};
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Shared multiplier: century reciprocal first, then days per year
    assign mul_b    = (state_reg == gda_pkg::ST_MUL_C) ? gda_pkg::MUL_RECIP100
                                                       : gda_pkg::MUL_YEAR;
    assign mul_prod = gda_pkg::MUL_P_W'(cy_reg) * gda_pkg::MUL_P_W'(mul_b);

    // Leap year of the working year and of the year before it
    assign leap_cur  = gda_pkg::is_leap(cy_reg[1:0], cc_reg[1:0], cr_reg);
    assign prev_y_lo = cy_reg[1:0] - 2'd1;
    assign prev_r    = (cr_reg == '0) ? gda_pkg::CREM_MAX : cr_reg - RW'(1);
    assign prev_c_lo = (cr_reg == '0) ? cc_reg[1:0] - 2'd1 : cc_reg[1:0];
    assign leap_prev = gda_pkg::is_leap(prev_y_lo, prev_c_lo, prev_r);

    assign dim_k  = gda_pkg::month_days(leap_cur, k_reg);
    assign dim_cm = gda_pkg::month_days(leap_cur, cm_reg);

    // Given date lies in the calendar
    assign date_ok = (cy_reg <= gda_pkg::MAX_YEAR) && (cd_reg != '0)
                     && (cd_reg <= dim_cm);

    // Century times 100 for the year remainder
    assign cent_x100 = (15'(cc_reg) << 6) + (15'(cc_reg) << 5) + (15'(cc_reg) << 2);

    // Leap days before the working year: ceil(y/4) - ceil(y/100) + ceil(y/400)
    assign r_nz = (cr_reg != '0);
    assign q4   = 12'((15'(cy_reg) + 15'd3) >> 2);
    assign q100 = 12'(cc_reg) + 12'(r_nz);
    assign q400 = 12'(cc_reg[CW-1:2]) + 12'((cc_reg[1:0] != 2'd0) || r_nz);
    assign lb   = q4 + q400 - q100;

    // Year walk step: forward for add, backward for subtract
    assign walk_len = (func_reg == gda_pkg::FUNC_ADD)
                      ? (leap_cur  ? gda_pkg::DAYS_YEAR_LP : gda_pkg::DAYS_YEAR)
                      : (leap_prev ? gda_pkg::DAYS_YEAR_LP : gda_pkg::DAYS_YEAR);
    assign walk_ys  = (func_reg == gda_pkg::FUNC_ADD) ? ys_reg + SW'(walk_len)
                                                      : ys_reg - SW'(walk_len);

    assign add_sum = acc_reg + SW'(cnt_reg);

    // Held date against given date, year then month then day
    always_comb begin
        priority if (held_year_reg != oy_reg) begin
            cmp_later = held_year_reg > oy_reg;
        end else if (held_month_reg != om_reg) begin
            cmp_later = held_month_reg > om_reg;
        end else begin
            cmp_later = held_day_reg > od_reg;
        end
        cmp_equal = (held_year_reg == oy_reg) && (held_month_reg == om_reg)
                    && (held_day_reg == od_reg);
    end

    // Sequencer: next state and work register updates
    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        cnt_next        = cnt_reg;
        oy_next         = oy_reg;
        om_next         = om_reg;
        od_next         = od_reg;
        held_year_next  = held_year_reg;
        held_month_next = held_month_reg;
        held_day_next   = held_day_reg;
        phase_next      = phase_reg;
        cy_next         = cy_reg;
        cm_next         = cm_reg;
        cd_next         = cd_reg;
        cc_next         = cc_reg;
        cr_next         = cr_reg;
        k_next          = k_reg;
        acc_next        = acc_reg;
        ys_next         = ys_reg;
        sb_next         = sb_reg;
        dist_next       = dist_reg;
        inv_next        = inv_reg;
        rerr_next       = rerr_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_year_next     = m_year_reg;
        m_month_next    = m_month_reg;
        m_day_next      = m_day_reg;
        m_later_next    = m_later_reg;
        m_equal_next    = m_equal_reg;
        m_dist_next     = m_dist_reg;
        m_inv_next      = m_inv_reg;
        m_rerr_next     = m_rerr_reg;

        unique case (state_reg)
            // Take a request and pick the first date to convert
            gda_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    func_next  = gda_pkg::func_t'(s_axis_tuser);
                    cnt_next   = s_axis_tdata[15:0];
                    oy_next    = s_axis_tdata[29:16];
                    om_next    = s_axis_tdata[33:30];
                    od_next    = s_axis_tdata[38:34];
                    phase_next = 1'b0;
                    dist_next  = '0;
                    inv_next   = 1'b0;
                    rerr_next  = 1'b0;
                    if ((gda_pkg::func_t'(s_axis_tuser) == gda_pkg::FUNC_LOAD)
                        || (gda_pkg::func_t'(s_axis_tuser) == gda_pkg::FUNC_COMPARE)) begin
                        cy_next = s_axis_tdata[29:16];
                        cm_next = s_axis_tdata[33:30];
                        cd_next = s_axis_tdata[38:34];
                    end else begin
                        cy_next = held_year_reg;
                        cm_next = held_month_reg;
                        cd_next = held_day_reg;
                    end
                    state_next = gda_pkg::ST_MUL_C;
                end
            end
            // Century of the working year by reciprocal multiply
            gda_pkg::ST_MUL_C: begin
                cc_next    = mul_prod[gda_pkg::RECIP_SHIFT +: CW];
                state_next = gda_pkg::ST_REM;
            end
            // Year within its century
            gda_pkg::ST_REM: begin
                cr_next    = RW'(15'(cy_reg) - cent_x100);
                state_next = gda_pkg::ST_CHECK;
            end
            // Validate a given date; a load ends here
            gda_pkg::ST_CHECK: begin
                if (((func_reg == gda_pkg::FUNC_LOAD)
                     || ((func_reg == gda_pkg::FUNC_COMPARE) && !phase_reg)) && !date_ok) begin
                    inv_next   = 1'b1;
                    state_next = gda_pkg::ST_DONE;
                end else if (func_reg == gda_pkg::FUNC_LOAD) begin
                    state_next = gda_pkg::ST_DONE;
                end else begin
                    state_next = gda_pkg::ST_MUL_Y;
                end
            end
            // Days in whole years before the working year
            gda_pkg::ST_MUL_Y: begin
                acc_next   = mul_prod[SW-1:0];
                state_next = gda_pkg::ST_YSUM;
            end
            // Add leap days; keep the year start and add the day of month
            gda_pkg::ST_YSUM: begin
                ys_next    = acc_reg + SW'(lb);
                acc_next   = acc_reg + SW'(lb) + SW'(cd_reg) - SW'(1);
                k_next     = gda_pkg::MONTH_FIRST;
                state_next = gda_pkg::ST_MON;
            end
            // Add one month length per cycle, then dispatch on the operation
            gda_pkg::ST_MON: begin
                if (k_reg < cm_reg) begin
                    acc_next = acc_reg + SW'(dim_k);
                    k_next   = k_reg + MW'(1);
                end else if ((func_reg == gda_pkg::FUNC_COMPARE) && !phase_reg) begin
                    sb_next    = acc_reg;
                    phase_next = 1'b1;
                    cy_next    = held_year_reg;
                    cm_next    = held_month_reg;
                    cd_next    = held_day_reg;
                    state_next = gda_pkg::ST_MUL_C;
                end else if (func_reg == gda_pkg::FUNC_COMPARE) begin
                    dist_next  = (acc_reg > sb_reg) ? acc_reg - sb_reg : sb_reg - acc_reg;
                    state_next = gda_pkg::ST_DONE;
                end else begin
                    state_next = gda_pkg::ST_ARITH;
                end
            end
            // Apply the day count and check the calendar range
            gda_pkg::ST_ARITH: begin
                if (func_reg == gda_pkg::FUNC_ADD) begin
                    if (add_sum > gda_pkg::LAST_SERIAL) begin
                        rerr_next  = 1'b1;
                        state_next = gda_pkg::ST_DONE;
                    end else begin
                        acc_next   = add_sum;
                        state_next = gda_pkg::ST_WALK;
                    end
                end else begin
                    if (acc_reg < SW'(cnt_reg)) begin
                        rerr_next  = 1'b1;
                        state_next = gda_pkg::ST_DONE;
                    end else begin
                        acc_next   = acc_reg - SW'(cnt_reg);
                        state_next = gda_pkg::ST_WALK;
                    end
                end
            end
            // Step one year per cycle until the target falls in the year
            gda_pkg::ST_WALK: begin
                if ((func_reg == gda_pkg::FUNC_ADD) && (acc_reg >= walk_ys)) begin
                    ys_next = walk_ys;
                    cy_next = cy_reg + YW'(1);
                    if (cr_reg == gda_pkg::CREM_MAX) begin
                        cr_next = '0;
                        cc_next = cc_reg + CW'(1);
                    end else begin
                        cr_next = cr_reg + RW'(1);
                    end
                end else if ((func_reg != gda_pkg::FUNC_ADD) && (acc_reg < ys_reg)) begin
                    ys_next = walk_ys;
                    cy_next = cy_reg - YW'(1);
                    cr_next = prev_r;
                    if (cr_reg == '0) begin
                        cc_next = cc_reg - CW'(1);
                    end
                end else begin
                    acc_next   = acc_reg - ys_reg;
                    cm_next    = gda_pkg::MONTH_FIRST;
                    state_next = gda_pkg::ST_MONW;
                end
            end
            // Step one month per cycle inside the final year
            gda_pkg::ST_MONW: begin
                if ((cm_reg < gda_pkg::MONTH_LAST) && (acc_reg >= SW'(dim_cm))) begin
                    acc_next = acc_reg - SW'(dim_cm);
                    cm_next  = cm_reg + MW'(1);
                end else begin
                    cd_next    = DW'(acc_reg) + DW'(1);
                    state_next = gda_pkg::ST_DONE;
                end
            end
            // Commit the held date and fill the output register
            gda_pkg::ST_DONE: begin
                if (out_free) begin
                    if ((func_reg == gda_pkg::FUNC_LOAD) && !inv_reg) begin
                        held_year_next  = oy_reg;
                        held_month_next = om_reg;
                        held_day_next   = od_reg;
                        m_year_next     = oy_reg;
                        m_month_next    = om_reg;
                        m_day_next      = od_reg;
                    end else if (((func_reg == gda_pkg::FUNC_ADD)
                                  || (func_reg == gda_pkg::FUNC_SUB)) && !rerr_reg) begin
                        held_year_next  = cy_reg;
                        held_month_next = cm_reg;
                        held_day_next   = cd_reg;
                        m_year_next     = cy_reg;
                        m_month_next    = cm_reg;
                        m_day_next      = cd_reg;
                    end else begin
                        m_year_next     = held_year_reg;
                        m_month_next    = held_month_reg;
                        m_day_next      = held_day_reg;
                    end
                    m_later_next = (func_reg == gda_pkg::FUNC_COMPARE) && cmp_later;
                    m_equal_next = (func_reg == gda_pkg::FUNC_COMPARE) && cmp_equal;
                    m_dist_next  = dist_reg;
                    m_inv_next   = inv_reg;
                    m_rerr_next  = rerr_reg;
                    m_valid_next = 1'b1;
                    state_next   = gda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = gda_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state and held date
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gda_pkg::ST_IDLE;
            m_valid_reg    <= 1'b0;
            held_year_reg  <= 14'd1900;
            held_month_reg <= gda_pkg::MONTH_FIRST;
            held_day_reg   <= 5'd1;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            held_year_reg  <= held_year_next;
            held_month_reg <= held_month_next;
            held_day_reg   <= held_day_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        cnt_reg     <= cnt_next;
        oy_reg      <= oy_next;
        om_reg      <= om_next;
        od_reg      <= od_next;
        phase_reg   <= phase_next;
        cy_reg      <= cy_next;
        cm_reg      <= cm_next;
        cd_reg      <= cd_next;
        cc_reg      <= cc_next;
        cr_reg      <= cr_next;
        k_reg       <= k_next;
        acc_reg     <= acc_next;
        ys_reg      <= ys_next;
        sb_reg      <= sb_next;
        dist_reg    <= dist_next;
        inv_reg     <= inv_next;
        rerr_reg    <= rerr_next;
        m_year_reg  <= m_year_next;
        m_month_reg <= m_month_next;
        m_day_reg   <= m_day_next;
        m_later_reg <= m_later_next;
        m_equal_reg <= m_equal_next;
        m_dist_reg  <= m_dist_next;
        m_inv_reg   <= m_inv_next;
        m_rerr_reg  <= m_rerr_next;
    end

endmodule

`default_nettype wire
